@@ sv/grc_pkg.sv @@
// grc_pkg: shared types and constants of the grid ray caster.
// Used by grc_front, grc_walk, grid_ray_cast and the testbench; depends on nothing.
package grc_pkg;

  // Configuration register width and reset values
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd256;

  // Linear cell index width: row * width + col with 11-bit row, col and width
  localparam int LIN_W = 2 * CFG_W;

  // Result field widths and stream bus widths
  localparam int DIST_W     = 33;
  localparam int M_TDATA_W  = 40;
  localparam int CELL_ADDR_W = 16;

  // Configuration bus
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] dist_sq;
  } result_t;

endpackage

@@ sv/grc_ram.sv @@
// grc_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/grc_queue.sv @@
// grc_queue: short FIFO between the ray front end and the walker.
// Entry type comes from the top level; uses no package items.
module grc_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  T     push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output T     pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ sv/grc_front.sv @@
// grc_front: accepts items, classifies them and prepares Bresenham setup.
// Uses grc_pkg (cfg_t, widths); entry type comes from the top level.
module grc_front #(
  parameter int  COORD_BITS = 16,
  parameter type entry_t    = logic
) (
  input  logic                                clk,
  input  logic                                rst,
  input  grc_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [grc_pkg::CELL_ADDR_W-1:0]     in_addr,
  input  logic                                in_blocked,
  input  logic signed [COORD_BITS-1:0]        in_c0,
  input  logic signed [COORD_BITS-1:0]        in_r0,
  input  logic signed [COORD_BITS-1:0]        in_c1,
  input  logic signed [COORD_BITS-1:0]        in_r1,
  output logic                                push_valid,
  input  logic                                push_ready,
  output entry_t                              push_data
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam int XW = ((COORD_BITS > grc_pkg::CFG_W) ? COORD_BITS : grc_pkg::CFG_W) + 1;
  localparam int LW = grc_pkg::LIN_W;

  // Stage 1: accepted item
  logic                             s1_valid;
  logic                             s1_op;
  logic [grc_pkg::CELL_ADDR_W-1:0]  s1_addr;
  logic                             s1_blocked;
  logic signed [CB-1:0]             s1_c0, s1_r0, s1_c1, s1_r1;

  // Stage 2: differences and start row product
  logic                             s2_valid;
  logic                             s2_op;
  logic [grc_pkg::CELL_ADDR_W-1:0]  s2_addr;
  logic                             s2_blocked;
  logic signed [CB-1:0]             s2_c0, s2_r0;
  logic [CB-1:0]                    s2_adc, s2_adr;
  logic                             s2_c_inc, s2_r_inc;
  logic [LW-1:0]                    s2_prod;

  logic s1_move;
  logic s2_free;

  assign s2_free  = !s2_valid || push_ready;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;

  // Stage 1 arithmetic: signed deltas, magnitudes, start row times width
  logic signed [CB:0]        s1_dc, s1_dr, s1_ndc, s1_ndr;
  logic [CB-1:0]             s1_adc, s1_adr;
  logic signed [XW-1:0]      s1_rowx;
  logic [LW-1:0]             s1_prod;

  assign s1_dc   = {s1_c1[CB-1], s1_c1} - {s1_c0[CB-1], s1_c0};
  assign s1_dr   = {s1_r1[CB-1], s1_r1} - {s1_r0[CB-1], s1_r0};
  assign s1_ndc  = -s1_dc;
  assign s1_ndr  = -s1_dr;
  assign s1_adc  = s1_dc[CB] ? s1_ndc[CB-1:0] : s1_dc[CB-1:0];
  assign s1_adr  = s1_dr[CB] ? s1_ndr[CB-1:0] : s1_dr[CB-1:0];
  assign s1_rowx = XW'(s1_r0);
  assign s1_prod = LW'(s1_rowx[grc_pkg::CFG_W-1:0]) * LW'(cfg.width);

  // Stage 2 arithmetic: axis swap, decision terms, linear index steps
  logic                 s2_steep;
  logic [CB-1:0]        s2_da, s2_db;
  logic signed [DW-1:0] s2_two_db, s2_two_da;
  logic signed [XW-1:0] s2_colx;
  logic [LW-1:0]        s2_col_step, s2_row_step, s2_sa, s2_sb;

  assign s2_steep    = s2_adc < s2_adr;
  assign s2_da       = s2_steep ? s2_adr : s2_adc;
  assign s2_db       = s2_steep ? s2_adc : s2_adr;
  assign s2_two_db   = $signed({2'b00, s2_db, 1'b0});
  assign s2_two_da   = $signed({2'b00, s2_da, 1'b0});
  assign s2_colx     = XW'(s2_c0);
  assign s2_col_step = s2_c_inc ? LW'(1) : '1;
  assign s2_row_step = s2_r_inc ? LW'(cfg.width) : (LW'(0) - LW'(cfg.width));
  assign s2_sa       = s2_steep ? s2_row_step : s2_col_step;
  assign s2_sb       = s2_steep ? s2_col_step : s2_row_step;

  // Build the queue entry
  always_comb begin
    push_data         = '0;
    push_data.op      = s2_op;
    push_data.addr    = s2_addr;
    push_data.blocked = s2_blocked;
    push_data.steep   = s2_steep;
    push_data.a0      = s2_steep ? s2_r0 : s2_c0;
    push_data.b0      = s2_steep ? s2_c0 : s2_r0;
    push_data.da      = s2_da;
    push_data.a_inc   = s2_steep ? s2_r_inc : s2_c_inc;
    push_data.b_inc   = s2_steep ? s2_c_inc : s2_r_inc;
    push_data.dec0    = s2_two_db - $signed({3'b000, s2_da});
    push_data.inc_s   = s2_two_db;
    push_data.inc_d   = s2_two_db - s2_two_da;
    push_data.lin0    = s2_prod + LW'(s2_colx[grc_pkg::CFG_W-1:0]);
    push_data.lin_sa  = s2_sa;
    push_data.lin_sab = s2_sa + s2_sb;
  end

  assign push_valid = s2_valid;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_move;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op      <= in_op;
      s1_addr    <= in_addr;
      s1_blocked <= in_blocked;
      s1_c0      <= in_c0;
      s1_r0      <= in_r0;
      s1_c1      <= in_c1;
      s1_r1      <= in_r1;
    end
    if (s1_move) begin
      s2_op      <= s1_op;
      s2_addr    <= s1_addr;
      s2_blocked <= s1_blocked;
      s2_c0      <= s1_c0;
      s2_r0      <= s1_r0;
      s2_adc     <= s1_adc;
      s2_adr     <= s1_adr;
      s2_c_inc   <= !s1_dc[CB] && (s1_dc != '0);
      s2_r_inc   <= !s1_dr[CB] && (s1_dr != '0);
      s2_prod    <= s1_prod;
    end
  end

endmodule

@@ sv/grc_walk.sv @@
// grc_walk: executes map writes and walks rays one cell per cycle.
// Uses grc_pkg (cfg_t, result_t, opcodes) and instantiates grc_ram.
module grc_walk #(
  parameter int  MAP_CELLS  = 65536,
  parameter int  COORD_BITS = 16,
  parameter type entry_t    = logic
) (
  input  logic             clk,
  input  logic             rst,
  input  grc_pkg::cfg_t    cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  entry_t           pop_data,
  output logic             res_valid,
  input  logic             res_ready,
  output grc_pkg::result_t res
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam int XW = ((COORD_BITS > grc_pkg::CFG_W) ? COORD_BITS : grc_pkg::CFG_W) + 1;
  localparam int LW = grc_pkg::LIN_W;
  localparam int AW = $clog2(MAP_CELLS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_SQUARE = 2'd2;
  localparam logic [1:0] ST_SUM    = 2'd3;

  logic [1:0] state;

  // Ray constants held for the walk
  logic                 steep, a_inc, b_inc;
  logic [CB-1:0]        da;
  logic signed [DW-1:0] inc_s, inc_d;
  logic [LW-1:0]        lin_sa, lin_sab;

  // Next cell to read
  logic                 issuing;
  logic signed [CB-1:0] cur_a, cur_b;
  logic [CB-1:0]        cur_na, cur_nb;
  logic signed [DW-1:0] cur_dec;
  logic [LW-1:0]        cur_lin;

  // Cell under check (its map bit arrives from the RAM)
  logic                 p_valid, p_oob, p_last;
  logic [CB-1:0]        p_na, p_nb;

  // Distance terms
  logic                 hit;
  logic [2*CB-1:0]      sq_a, sq_b;
  logic [2*CB:0]        sq_sum;

  logic                 pop_fire, cast_pop, map_we, ram_bit;
  logic                 issue, cur_last, diag, p_stop, chk_done, res_load;
  logic signed [CB-1:0] col, row;
  logic signed [XW-1:0] colx, rowx;
  logic                 cur_oob;

  assign pop_ready = (state == ST_IDLE);
  assign pop_fire  = pop_valid && pop_ready;
  assign cast_pop  = pop_fire && (pop_data.op == grc_pkg::OP_CAST);
  assign map_we    = pop_fire && (pop_data.op == grc_pkg::OP_WRITE)
                     && (32'(pop_data.addr) < 32'(MAP_CELLS));

  // Bounds of the next cell
  assign col     = steep ? cur_b : cur_a;
  assign row     = steep ? cur_a : cur_b;
  assign colx    = XW'(col);
  assign rowx    = XW'(row);
  assign cur_oob = colx[XW-1] || rowx[XW-1]
                   || (colx[XW-2:0] >= (XW-1)'(cfg.width))
                   || (rowx[XW-2:0] >= (XW-1)'(cfg.height))
                   || (cur_lin >= LW'(MAP_CELLS));

  // Stop issuing once the cell under check ends the walk
  assign issue    = (state == ST_WALK) && issuing && !chk_done;
  assign cur_last = (cur_na == da);
  assign diag     = !cur_dec[DW-1] && (cur_dec != '0);
  assign p_stop   = p_oob || ram_bit;
  assign chk_done = (state == ST_WALK) && p_valid && (p_stop || p_last);
  assign res_load = (state == ST_SUM) && (!res_valid || res_ready);
  assign sq_sum   = {1'b0, sq_a} + {1'b0, sq_b};

  grc_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (AW'(pop_data.addr)),
    .wdata (pop_data.blocked),
    .re    (issue),
    .raddr (cur_lin[AW-1:0]),
    .rdata (ram_bit)
  );

  // Sequencer and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issuing   <= 1'b0;
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cast_pop) begin
            state   <= ST_WALK;
            issuing <= 1'b1;
            p_valid <= 1'b0;
          end
        end
        ST_WALK: begin
          if (chk_done) begin
            state   <= ST_SQUARE;
            issuing <= 1'b0;
            p_valid <= 1'b0;
          end else begin
            p_valid <= issue;
            if (issue && cur_last) begin
              issuing <= 1'b0;
            end
          end
        end
        ST_SQUARE: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (res_load) begin
            state     <= ST_IDLE;
            res_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (cast_pop) begin
      steep   <= pop_data.steep;
      a_inc   <= pop_data.a_inc;
      b_inc   <= pop_data.b_inc;
      da      <= pop_data.da;
      inc_s   <= pop_data.inc_s;
      inc_d   <= pop_data.inc_d;
      lin_sa  <= pop_data.lin_sa;
      lin_sab <= pop_data.lin_sab;
      cur_a   <= pop_data.a0;
      cur_b   <= pop_data.b0;
      cur_na  <= '0;
      cur_nb  <= '0;
      cur_dec <= pop_data.dec0;
      cur_lin <= pop_data.lin0;
    end
    // Record the cell being read, then step to the next one
    if (issue) begin
      p_oob  <= cur_oob;
      p_last <= cur_last;
      p_na   <= cur_na;
      p_nb   <= cur_nb;
      if (!cur_last) begin
        cur_a  <= cur_a + (a_inc ? CB'(1) : '1);
        cur_na <= cur_na + CB'(1);
        if (diag) begin
          cur_b   <= cur_b + (b_inc ? CB'(1) : '1);
          cur_nb  <= cur_nb + CB'(1);
          cur_dec <= cur_dec + inc_d;
          cur_lin <= cur_lin + lin_sab;
        end else begin
          cur_dec <= cur_dec + inc_s;
          cur_lin <= cur_lin + lin_sa;
        end
      end
    end
    if (chk_done) begin
      hit <= p_stop;
    end
    if (state == ST_SQUARE) begin
      sq_a <= p_na * p_na;
      sq_b <= p_nb * p_nb;
    end
    if (res_load) begin
      res.hit     <= hit;
      res.dist_sq <= hit ? grc_pkg::DIST_W'(sq_sum) : '0;
    end
  end

endmodule

@@ sv/grid_ray_cast.sv @@
// grid_ray_cast: one-bit occupancy map with a Bresenham ray caster.
// Depends on grc_pkg, grc_front, grc_queue, grc_walk and grc_ram.
//
// Usage:
//   Input stream (s_axis): tuser selects the transaction kind. A write stores
//   cell_blocked at cell_addr and returns nothing. A cast walks from the start
//   cell toward the end cell and returns one result on m_axis: tuser = hit,
//   tdata = squared cell distance to the stopping cell (0 when no hit).
//   APB port: map_width at 0x0, map_height at 0x4, written between casts.
// Timing:
//   A transaction passes two front stages and a two-entry queue. A write
//   does not hold the walker. A cast holds the walker while it is taken,
//   while it reads one map cell per cycle on the single RAM read port, while
//   the last cell read is checked and while the distance is squared and
//   summed (ST_SQUARE, ST_SUM). Casts are walked one at a time.
// Reset: flow control and configuration clear (256 x 256 map); map contents
//   are undefined until written.
// Stall: a result waits in the output register; the front and the queue keep
//   accepting until the queue fills, and the walker holds its next result
//   until the output register frees.
module grid_ray_cast #(
  parameter int MAP_CELLS  = 65536,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_axis_tdata, low to high: cell_addr[15:0], cell_blocked, start_col,
  // start_row, end_col, end_row, zero pad to whole bytes
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((17 + 4*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // s_axis_tuser: opcode
  input  logic                               s_axis_tuser,
  // m_axis_tdata, low to high: dist_sq[32:0], zero pad
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [grc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // m_axis_tuser: hit
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [grc_pkg::APB_AW-1:0]         paddr,
  input  logic [grc_pkg::APB_DW-1:0]         pwdata,
  output logic [grc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam int LW = grc_pkg::LIN_W;
  localparam int AWD = grc_pkg::CELL_ADDR_W;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                 op;
    logic [AWD-1:0]       addr;
    logic                 blocked;
    logic                 steep;
    logic signed [CB-1:0] a0;
    logic signed [CB-1:0] b0;
    logic [CB-1:0]        da;
    logic                 a_inc;
    logic                 b_inc;
    logic signed [DW-1:0] dec0;
    logic signed [DW-1:0] inc_s;
    logic signed [DW-1:0] inc_d;
    logic [LW-1:0]        lin0;
    logic [LW-1:0]        lin_sa;
    logic [LW-1:0]        lin_sab;
  } entry_t;

  grc_pkg::cfg_t    cfg;
  grc_pkg::result_t res;
  logic             cfg_write;
  logic             q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  entry_t           q_push_data, q_pop_data;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= grc_pkg::WIDTH_RESET;
      cfg.height <= grc_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        grc_pkg::REG_WIDTH:  cfg.width  <= pwdata[grc_pkg::CFG_W-1:0];
        grc_pkg::REG_HEIGHT: cfg.height <= pwdata[grc_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = grc_pkg::APB_DW'((paddr[2] == grc_pkg::REG_HEIGHT) ? cfg.height
                                                                     : cfg.width);

  grc_front #(
    .COORD_BITS (COORD_BITS),
    .entry_t    (entry_t)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_addr    (s_axis_tdata[AWD-1:0]),
    .in_blocked (s_axis_tdata[AWD]),
    .in_c0      (s_axis_tdata[AWD+1 +: CB]),
    .in_r0      (s_axis_tdata[AWD+1+CB +: CB]),
    .in_c1      (s_axis_tdata[AWD+1+2*CB +: CB]),
    .in_r1      (s_axis_tdata[AWD+1+3*CB +: CB]),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  grc_queue #(
    .T     (entry_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  grc_walk #(
    .MAP_CELLS  (MAP_CELLS),
    .COORD_BITS (COORD_BITS),
    .entry_t    (entry_t)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {{(grc_pkg::M_TDATA_W - grc_pkg::DIST_W){1'b0}}, res.dist_sq};

`ifndef ASSERT_OFF
  // Configuration changes only through an APB write
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_write |=> $stable(cfg))
    else $error("configuration changed without a write");

  // A cast occupies the walker for at least the next cycle
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop_valid && q_pop_ready && (q_pop_data.op == grc_pkg::OP_CAST) |=> !q_pop_ready)
    else $error("walker took a new entry right after a cast");

  // A map write leaves the walker free for the next entry
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    q_pop_valid && q_pop_ready && (q_pop_data.op == grc_pkg::OP_WRITE) |=> q_pop_ready)
    else $error("walker stalled after a map write");

  // Front keeps its entry while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && !q_push_ready |=> q_push_valid)
    else $error("front dropped an entry while the queue was full");
`endif

endmodule

@@ sim/tb_grid_ray_cast.sv @@
// tb_grid_ray_cast: self-checking testbench for the grid ray caster.
// Depends on grc_pkg and grid_ray_cast; drives the stream and APB ports and
// checks every cast result against an in-bench Bresenham walk over a map copy.
module tb_grid_ray_cast;
  timeunit 1ns;
  timeprecision 1ps;

  import grc_pkg::*;

  localparam int MAP_CELLS     = 65536;
  localparam int S_TDATA_W     = ((17 + 4 * 16 + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int PHASE_ITEMS   = 75;

  typedef enum {CELL_FREE, CELL_BLOCKED, CELL_OUTSIDE, CELL_UNSET} cell_kind_t;

  // Map copy, map size and the queue of casts still waiting for their result
  class ray_scoreboard;
    bit        occ [MAP_CELLS];
    bit        seen [MAP_CELLS];
    longint    map_w;
    longint    map_h;
    result_t   pending [$];
    int        errors;

    function new();
      map_w  = longint'(WIDTH_RESET);
      map_h  = longint'(HEIGHT_RESET);
      errors = 0;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Classify one cell; addr is its linear address when it lies on the map
    function cell_kind_t probe(longint col, longint row, output int unsigned addr);
      longint lin;
      addr = 0;
      if (col < 0 || row < 0 || col >= map_w || row >= map_h) return CELL_OUTSIDE;
      lin = row * map_w + col;
      if (lin >= MAP_CELLS) return CELL_OUTSIDE;
      addr = 32'(lin);
      if (!seen[addr]) return CELL_UNSET;
      return occ[addr] ? CELL_BLOCKED : CELL_FREE;
    endfunction

    // Walk the ray until a stopping cell, the end cell, or a cell never written
    function void walk(input logic signed [15:0] sc, sr, ec, er,
                       output bit stopped, output bit unset,
                       output int unsigned addr, output logic [DIST_W-1:0] dsq);
      longint     c0, r0, c1, r1, a0, b0, a1, b1, da, db, a, b, err, astep, bstep;
      bit         steep;
      cell_kind_t kind;
      c0 = longint'(sc);
      r0 = longint'(sr);
      c1 = longint'(ec);
      r1 = longint'(er);
      steep = mag(c1 - c0) < mag(r1 - r0);
      if (steep) begin
        a0 = r0; b0 = c0; a1 = r1; b1 = c1;
      end else begin
        a0 = c0; b0 = r0; a1 = c1; b1 = r1;
      end
      da    = mag(a1 - a0);
      db    = mag(b1 - b0);
      astep = (a1 > a0) ? 1 : -1;
      bstep = (b1 > b0) ? 1 : -1;
      a     = a0;
      b     = b0;
      err   = 0;
      kind  = steep ? probe(b, a, addr) : probe(a, b, addr);
      while (kind == CELL_FREE && a != a1) begin
        a   += astep;
        err += db;
        if (2 * err > da) begin
          b   += bstep;
          err -= da;
        end
        kind = steep ? probe(b, a, addr) : probe(a, b, addr);
      end
      unset   = (kind == CELL_UNSET);
      stopped = (kind == CELL_BLOCKED || kind == CELL_OUTSIDE);
      dsq     = DIST_W'(mag(a - a0) * mag(a - a0) + mag(b - b0) * mag(b - b0));
    endfunction

    // Record an accepted transaction: update the map or queue the cast result
    function void note_item(logic op, logic [15:0] addr, logic blocked,
                            logic signed [15:0] sc, sr, ec, er);
      bit                stopped, unset;
      int unsigned       gap;
      logic [DIST_W-1:0] dsq;
      result_t           want;
      if (op == OP_WRITE) begin
        occ[addr]  = blocked;
        seen[addr] = 1'b1;
      end else begin
        walk(sc, sr, ec, er, stopped, unset, gap, dsq);
        if (unset) begin
          errors++;
          $display("%0t: cast reads cell %0d before any write", $time, gap);
        end
        want.hit     = stopped;
        want.dist_sq = stopped ? dsq : '0;
        pending.insert(pending.size(), want);
      end
    endfunction

    // Compare one result with the oldest queued cast
    function void check_result(logic hit, logic [DIST_W-1:0] dsq);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no cast pending, hit=%0b dist_sq=%0d", $time, hit, dsq);
        return;
      end
      want = pending.pop_front();
      if (hit !== want.hit) begin
        errors++;
        $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
      end
      if (dsq !== want.dist_sq) begin
        errors++;
        $display("%0t: dist_sq mismatch, expected %0d actual %0d",
                 $time, want.dist_sq, dsq);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // s_axis_tdata, low to high: cell_addr, cell_blocked, start_col, start_row,
  // end_col, end_row, zero pad
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  // s_axis_tuser: opcode
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // m_axis_tdata, low to high: dist_sq, zero pad
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // m_axis_tuser: hit
  logic                  m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  ray_scoreboard sb;
  int            cycles;
  int            items_sent;
  int            block_pct;
  bit            src_idle;
  bit            sink_idle;
  bit            calm;

  grid_ray_cast u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL grid_ray_cast");
      $finish;
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[DIST_W-1:0]);
  end

  // Stall the result side in random bursts
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && sink_idle && $urandom_range(2, 0) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  // Drive one input transaction after an optional gap and wait for acceptance
  task automatic send_item(logic op, logic [15:0] addr, logic blocked,
                           logic signed [15:0] sc, sr, ec, er);
    if (!calm && src_idle && $urandom_range(3, 0) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, er, ec, sr, sc, blocked, addr};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, addr, blocked, sc, sr, ec, er);
    items_sent++;
  endtask

  task automatic write_cell(int unsigned addr, logic blocked);
    send_item(OP_WRITE, 16'(addr), blocked, 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()));
  endtask

  // Write every map cell the ray would read first, then cast it
  task automatic cast_ray(int sc, int sr, int ec, int er);
    logic signed [15:0] c0, r0, c1, r1;
    bit                 stopped, unset;
    int unsigned        gap;
    logic [DIST_W-1:0]  dsq;
    c0 = 16'(sc);
    r0 = 16'(sr);
    c1 = 16'(ec);
    r1 = 16'(er);
    sb.walk(c0, r0, c1, r1, stopped, unset, gap, dsq);
    while (unset) begin
      write_cell(gap, $urandom_range(99, 0) < block_pct);
      sb.walk(c0, r0, c1, r1, stopped, unset, gap, dsq);
    end
    send_item(OP_CAST, 16'($urandom()), 1'($urandom_range(1, 0)), c0, r0, c1, r1);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Hold input until every cast result is back and trailing writes have drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_map(int w, int h);
    settle();
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    sb.map_w = w;
    sb.map_h = h;
  endtask

  // Mostly rays that start on the map with random reach, plus noise items
  task automatic run_phase(int n);
    int stop_at, pick, reach, sc, sr, ec, er;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 12) begin
        write_cell($urandom(), 1'($urandom_range(1, 0)));
      end else if (pick < 22) begin
        cast_ray($urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        if ($urandom_range(9, 0) == 0)
          reach = int'((sb.map_w > sb.map_h) ? sb.map_w : sb.map_h) + 8;
        else
          reach = $urandom_range(24, 0);
        sc = $urandom_range(int'(sb.map_w) - 1, 0);
        sr = $urandom_range(int'(sb.map_h) - 1, 0);
        ec = sc + int'($urandom_range(2 * reach, 0)) - reach;
        er = sr + int'($urandom_range(2 * reach, 0)) - reach;
        cast_ray(sc, sr, ec, er);
      end
    end
  endtask

  initial begin
    int phase_w [6] = '{1024, 64, 1024, 37, 1, 256};
    int phase_h [6] = '{64, 1024, 1024, 200, 1024, 256};
    sb            = new();
    cycles        = 0;
    items_sent    = 0;
    block_pct     = 20;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    calm          = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_WRITE;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst           <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every exit edge, blocked start, single-cell rays
    write_cell(0, 1'b0);
    write_cell('hFFFF, 1'b1);
    cast_ray(0, 0, 0, 0);
    cast_ray(255, 255, 255, 255);
    cast_ray(255, 255, 250, 250);
    cast_ray(-1, 5, 10, 5);
    cast_ray(5, -1, 5, 10);
    cast_ray(-32768, -32768, 32767, 32767);
    cast_ray(32767, 32767, -32768, -32768);
    cast_ray(250, 10, 300, 12);
    cast_ray(10, 250, 12, 300);
    cast_ray(3, 100, -5, 100);
    cast_ray(100, 3, 100, -5);
    cast_ray(20, 20, 30, 27);
    cast_ray(20, 20, 13, 35);
    cast_ray(50, 50, 60, 60);
    cast_ray(60, 60, 50, 70);
    write_cell(30 * 256 + 35, 1'b1);
    cast_ray(30, 30, 40, 30);
    cast_ray(30, 30, 35, 30);

    // Zero-width map stops every ray at its start; then rays on a one-cell map
    set_map(0, 5);
    cast_ray(0, 0, 3, 3);
    cast_ray(-2, 1, 0, 0);
    set_map(1, 1);
    cast_ray(0, 0, 0, 0);
    cast_ray(0, 0, 5, 0);
    cast_ray(0, 0, 0, -3);

    // Random phases over several map shapes; the last one runs without idling
    for (int p = 0; p < 6; p++) begin
      set_map(phase_w[p], phase_h[p]);
      block_pct = $urandom_range(40, 5);
      src_idle  = $urandom_range(3, 0) != 0;
      sink_idle = $urandom_range(3, 0) != 0;
      calm      = (p == 5);
      run_phase(PHASE_ITEMS);
    end

    settle();
    if (sb.errors == 0)
      $display("PASS grid_ray_cast");
    else
      $display("FAIL grid_ray_cast");
    $finish;
  end

endmodule

@@ sim.f @@
sv/grc_pkg.sv
sv/grc_ram.sv
sv/grc_queue.sv
sv/grc_front.sv
sv/grc_walk.sv
sv/grid_ray_cast.sv
sim/tb_grid_ray_cast.sv
